>>> rtl/pfla_pkg.sv
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared types and constants for the free-list page allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

  localparam int ADDR_W     = 28;
  localparam int PAGE_SHIFT = 12;
  localparam int PN_W       = ADDR_W - PAGE_SHIFT;  // page number width
  localparam int SIZE_W     = 29;
  localparam int CNT_W      = SIZE_W - PAGE_SHIFT;  // page count width
  localparam int CFG_IDX_W  = 2;

  localparam logic [ADDR_W-1:0] PROT_LIMIT_RST   = 28'h0210000;
  localparam logic [ADDR_W-1:0] KERNEL_START_RST = 28'h0100000;
  localparam logic [ADDR_W-1:0] KERNEL_END_RST   = 28'h01FFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROT_LIMIT   = 2'd0,
    CFG_KERNEL_START = 2'd1,
    CFG_KERNEL_END   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ACT_ADD_REGION = 2'd0,
    ACT_FREE       = 2'd1,
    ACT_ALLOC      = 2'd2,
    ACT_NOP        = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_ALLOC_RD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prot_limit;
    logic [ADDR_W-1:0] kernel_start;
    logic [ADDR_W-1:0] kernel_end;
  } pfla_cfg_t;

endpackage

>>> rtl/pfla_page_check.sv
// ----------------------------------------------------------------------------
// pfla_page_check
// Compare unit: decides whether a page number may go on the free list.
// ----------------------------------------------------------------------------
module pfla_page_check
  import pfla_pkg::*;
(
  input  logic [PN_W-1:0] page_num,
  input  pfla_cfg_t       cfg,
  output logic            page_ok
);

  logic [ADDR_W-1:0] addr;
  logic              in_kernel;

  assign addr      = {page_num, {PAGE_SHIFT{1'b0}}};
  assign in_kernel = (addr >= cfg.kernel_start) && (addr <= cfg.kernel_end);
  assign page_ok   = (page_num != '0) && (addr > cfg.prot_limit) && !in_kernel;

endmodule

>>> rtl/page_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// page_free_list_allocator_top
// Page allocator keeping free pages on a LIFO linked list in a link memory.
// ----------------------------------------------------------------------------
// One item is handled at a time. A free goes from the idle state to the finish
// state, which loads the result register. An allocate from a non-empty list
// first passes through the read state, because it needs one registered read of
// the link memory. An add-region sweeps the pages of the rounded region below
// the top of the address space: the sweep runs each page through the single
// page-check comparator and the one write port of the link memory, one page
// per cycle, and then sees the end of the region before the finish state.
// The link memory is not cleared after reset, so the block accepts items right
// away. Results sit in an output register, so a new item is accepted while a
// result waits to be taken.
module page_free_list_allocator_top
  import pfla_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           action,
  input  logic [ADDR_W-1:0]    region_base,
  input  logic [SIZE_W-1:0]    region_size,
  input  logic [ADDR_W-1:0]    page_addr,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_W-1:0]    granted_page,
  output logic                 list_empty
);

  state_t            state, state_next;
  pfla_cfg_t         cfg;
  logic [PN_W-1:0]   free_head;
  logic [PN_W:0]     cur_pn;
  logic [CNT_W-1:0]  remaining;
  logic [ADDR_W-1:0] res_granted;
  logic              res_empty;

  logic [PN_W-1:0]   link_mem [2**PN_W];
  logic [PN_W-1:0]   rd_data;

  logic              in_acc;
  logic              sweep_done;
  logic              page_ok;
  logic              out_free;
  logic              mem_we;
  logic [PN_W-1:0]   mem_waddr;
  logic              mem_re;
  logic              load_out;
  logic              sweep_step;
  action_t           act;

  assign act        = action_t'(action);
  assign in_acc     = in_valid && !in_stall;
  assign sweep_done = (remaining == '0) || cur_pn[PN_W];
  assign out_free   = !out_valid || !out_stall;

  pfla_page_check u_check (
    .page_num (cur_pn[PN_W-1:0]),
    .cfg      (cfg),
    .page_ok  (page_ok)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prot_limit   <= PROT_LIMIT_RST;
      cfg.kernel_start <= KERNEL_START_RST;
      cfg.kernel_end   <= KERNEL_END_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PROT_LIMIT:   cfg.prot_limit   <= cfg_data;
        CFG_KERNEL_START: cfg.kernel_start <= cfg_data;
        CFG_KERNEL_END:   cfg.kernel_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (act)
            ACT_ADD_REGION: state_next = ST_SWEEP;
            ACT_ALLOC:      state_next = (free_head != '0) ? ST_ALLOC_RD : ST_FINISH;
            default:        state_next = ST_FINISH;
          endcase
        end
      end
      ST_SWEEP:    if (sweep_done) state_next = ST_FINISH;
      ST_ALLOC_RD: state_next = ST_FINISH;
      ST_FINISH:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall   = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = cur_pn[PN_W-1:0];
    mem_re     = 1'b0;
    load_out   = 1'b0;
    sweep_step = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        mem_waddr = page_addr[ADDR_W-1:PAGE_SHIFT];
        if (in_valid) begin
          mem_we = (act == ACT_FREE) && (page_addr[ADDR_W-1:PAGE_SHIFT] != '0);
          mem_re = (act == ACT_ALLOC) && (free_head != '0);
        end
      end
      ST_SWEEP: begin
        sweep_step = !sweep_done;
        mem_we     = !sweep_done && page_ok;
      end
      ST_FINISH: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // link memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_waddr] <= free_head;
    if (mem_re) rd_data <= link_mem[free_head];
  end

  // list head: push on write, pop after the read returns
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
    end else if (mem_we) begin
      free_head <= mem_waddr;
    end else if (state == ST_ALLOC_RD) begin
      free_head <= rd_data;
    end
  end

  // sweep counters and pending result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_pn      <= {1'b0, region_base[ADDR_W-1:PAGE_SHIFT]}
                     + {{PN_W{1'b0}}, |region_base[PAGE_SHIFT-1:0]};
      remaining   <= region_size[SIZE_W-1:PAGE_SHIFT];
      res_granted <= '0;
      res_empty   <= (act == ACT_ALLOC) && (free_head == '0);
    end else if (sweep_step) begin
      cur_pn    <= cur_pn + 1'b1;
      remaining <= remaining - 1'b1;
    end else if (state == ST_ALLOC_RD) begin
      res_granted <= {free_head, {PAGE_SHIFT{1'b0}}};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      granted_page <= res_granted;
      list_empty   <= res_empty;
    end
  end

  a_empty_keeps_head: assert property (@(posedge clk) disable iff (rst)
    (in_acc && act == ACT_ALLOC && free_head == '0) |=> (free_head == '0))
    else $error("empty allocate changed the list head");

  a_alloc_reads: assert property (@(posedge clk) disable iff (rst)
    (in_acc && act == ACT_ALLOC && free_head != '0) |=> (state == ST_ALLOC_RD))
    else $error("allocate skipped the link read");

  a_no_push_zero: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (mem_waddr != '0))
    else $error("page zero pushed onto the free list");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && list_empty) |-> (granted_page == '0))
    else $error("empty result carries a page address");

endmodule
